FILE: rtl/core/swlps_pkg.sv
package swlps_pkg;

	// Frame geometry and number of harmonics.
	localparam int WIDTH  = 1920;
	localparam int HEIGHT = 1080;
	localparam int WAVES  = 8;

	// Configuration port.
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE      = 3'd5;

	localparam logic [23:0] TIME_STEP_RST = 24'd135073;
	localparam logic [14:0] AMP_RST       = 15'd2294;
	localparam logic [15:0] GAIN_RST      = 16'd25166;
	localparam logic [15:0] RED_RST       = 16'd11878;
	localparam logic [15:0] GREEN_RST     = 16'd0;
	localparam logic [15:0] BLUE_RST      = 16'd4096;

	// Coordinate normalization: floor((v << 15) / N) by reciprocal multiplication.
	// The shift is chosen so that the product is exact for every 11-bit input.
	localparam int PX_K = 11 + $clog2(WIDTH);
	localparam int PY_K = 11 + $clog2(HEIGHT);
	localparam longint unsigned PX_MUL =
		((64'd1 << (15 + PX_K)) + 64'(WIDTH) - 64'd1) / 64'(WIDTH);
	localparam longint unsigned PY_MUL =
		((64'd1 << (15 + PY_K)) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT);
	localparam int PROD_W = 48;
	localparam int XQ_W   = 23;

	// Angle and sine polynomial constants.
	localparam logic [31:0] TURN_PER_Q14   = 32'd41722;
	localparam logic [31:0] TURN_PER_FIFTH = 32'd136713055;
	localparam logic [16:0] SIN_A          = 17'd102939;
	localparam logic [15:0] SIN_B          = 16'd42155;
	localparam logic [12:0] SIN_C          = 13'd4765;

	localparam int SIN_STAGES = 5;
	localparam int D_W        = 14;

	// Displaced y and divider widths.
	localparam int SPY_W      = 17 + $clog2(WAVES + 1);
	localparam int MAG_W      = SPY_W - 1;
	localparam int DEN_W      = MAG_W + 6;
	localparam int NUM_W      = 32;
	localparam int QUO_W      = 17;
	localparam int DIV_STAGES = QUO_W + 1;
	localparam int TERM_W     = QUO_W;
	localparam logic [TERM_W-1:0] TERM_FULL_VAL = 17'h10000;
	localparam int SUM_W      = TERM_W + $clog2(WAVES);

	localparam logic [7:0] ALPHA = 8'hFF;

	typedef struct packed {
		logic           neg;
		logic [D_W-1:0] mag;
	} disp_t;

	function automatic logic signed [15:0] sat_q14(input logic signed [24:0] v);
		logic signed [15:0] r;
		if (v > 25'sd32767) begin
			r = 16'sd32767;
		end else if (v < -25'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/swlps_sine.sv
module swlps_sine (
	input  logic                             clk,
	input  logic [swlps_pkg::SIN_STAGES-1:0] en,
	input  logic [31:0]                      ang,
	input  logic [14:0]                      amp,
	output swlps_pkg::disp_t                 disp
);
	import swlps_pkg::*;

	logic [15:0] f_c;
	logic [16:0] z_c;
	logic [33:0] zz_c;
	logic [29:0] p2_c;
	logic [32:0] p3_c;
	logic [33:0] p4_c;
	logic [16:0] s_c;
	logic [29:0] p5_c;

	logic [16:0] z_s1, z2_s1;
	logic        neg_s1;
	logic [16:0] z_s2, z2_s2;
	logic [15:0] t1_s2;
	logic        neg_s2;
	logic [16:0] z_s3, t2_s3;
	logic        neg_s3;
	logic [14:0] s15_s4;
	logic        neg_s4;
	logic [D_W-1:0] d_s5;
	logic        neg_s5;

	// The odd quadrants mirror the fraction of the quarter turn.
	always_comb begin
		f_c  = ang[29:14];
		z_c  = ang[30] ? (17'h10000 - {1'b0, f_c}) : {1'b0, f_c};
		zz_c = 34'(z_c) * 34'(z_c);
		p2_c = 30'(z2_s1) * 30'(SIN_C);
		p3_c = 33'(z2_s2) * 33'(t1_s2);
		p4_c = 34'(z_s3) * 34'(t2_s3);
		s_c  = p4_c[33:17];
		p5_c = 30'(amp) * 30'(s15_s4);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s1   <= z_c;
			z2_s1  <= zz_c[32:16];
			neg_s1 <= ang[31];
		end
		if (en[1]) begin
			z_s2   <= z_s1;
			z2_s2  <= z2_s1;
			t1_s2  <= SIN_B - 16'(p2_c[29:16]);
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			z_s3   <= z_s2;
			t2_s3  <= SIN_A - p3_c[32:16];
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			s15_s4 <= (s_c > 17'd32767) ? 15'd32767 : s_c[14:0];
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			d_s5   <= p5_c[29:16];
			neg_s5 <= neg_s4;
		end
	end

	assign disp = '{neg: neg_s5, mag: d_s5};

endmodule

FILE: rtl/core/swlps_div.sv
module swlps_div (
	input  logic                             clk,
	input  logic [swlps_pkg::DIV_STAGES-1:0] en,
	input  logic [swlps_pkg::NUM_W-1:0]      num,
	input  logic                             wzero,
	input  logic [swlps_pkg::MAG_W-1:0]      mag,
	output logic [swlps_pkg::TERM_W-1:0]     term
);
	import swlps_pkg::*;

	typedef enum logic [1:0] {K_DIV, K_ZERO, K_FULL} kind_t;

	logic [DEN_W-1:0] den_c;
	kind_t            kind_c;

	logic [NUM_W-1:0] rem_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s  [DIV_STAGES];
	logic [QUO_W-1:0] quo_s  [DIV_STAGES];
	kind_t            kind_s [DIV_STAGES];

	// A quotient that would not fit in the restoring steps saturates up front.
	always_comb begin
		den_c = {mag, 6'b0};
		if (wzero) begin
			kind_c = K_ZERO;
		end else if (mag == '0) begin
			kind_c = K_FULL;
		end else if ((num >> QUO_W) >= NUM_W'(den_c)) begin
			kind_c = K_FULL;
		end else begin
			kind_c = K_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= num;
			den_s[0]  <= den_c;
			quo_s[0]  <= '0;
			kind_s[0] <= kind_c;
		end
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
		localparam int B = QUO_W - j;
		logic [NUM_W-1:0] shd;
		logic             fit;

		always_comb begin
			shd = NUM_W'(den_s[j-1]) << B;
			fit = (rem_s[j-1] >> B) >= NUM_W'(den_s[j-1]);
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= fit ? (rem_s[j-1] - shd) : rem_s[j-1];
				quo_s[j]  <= quo_s[j-1] | (fit ? (QUO_W'(1) << B) : '0);
				den_s[j]  <= den_s[j-1];
				kind_s[j] <= kind_s[j-1];
			end
		end
	end

	always_comb begin
		case (kind_s[DIV_STAGES-1])
			K_ZERO: term = '0;
			K_FULL: term = TERM_FULL_VAL;
			default: begin
				term = (quo_s[DIV_STAGES-1] > TERM_FULL_VAL) ? TERM_FULL_VAL
					: quo_s[DIV_STAGES-1];
			end
		endcase
	end

endmodule

FILE: rtl/core/sine_wave_line_pixel_shader_unit.sv
// Sine-wave line pixel shader. Each input transaction carries one pixel
// coordinate and produces exactly one output transaction with its packed ARGB
// color (alpha always 0xFF). The pipeline accepts one pixel per clock unless
// a stall holds its input; most of its depth is the five-stage sine lanes and
// the 18-stage restoring dividers that form the line-intensity terms, a
// loading stage and then one quotient bit per stage. Every stage carries a
// valid bit and a stage only holds when it is full and the stage after it
// cannot take its data, so bubbles are squeezed out and input is still taken
// while a finished result waits on the output, as long as a stage is empty.
// The animation phase advances by time_step when the last pixel of a row is
// accepted; that pixel still uses the old phase.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and should only be changed while no transaction is in flight.
module sine_wave_line_pixel_shader_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swlps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swlps_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [10:0]                     pixel_x,
	input  logic [10:0]                     pixel_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     argb
);
	import swlps_pkg::*;

	// Stage map: two coordinate stages, the sine lanes, the displacement
	// accumulation, the dividers, the channel sums and the output register.
	localparam int SIN_BASE = 2;
	localparam int SPY_ST   = SIN_BASE + SIN_STAGES;
	localparam int DIV_BASE = SPY_ST + 1;
	localparam int SUM_ST   = DIV_BASE + DIV_STAGES;
	localparam int OUT_ST   = SUM_ST + 1;
	localparam int NS       = OUT_ST + 1;

	// Configuration registers.
	logic [23:0] time_step_q;
	logic [14:0] amp_q;
	logic [15:0] gain_q;
	logic [15:0] red_q;
	logic [15:0] green_q;
	logic [15:0] blue_q;
	logic [31:0] time_phase_q;

	logic [15:0]      wgt   [3];
	logic             wzero [3];
	logic [NUM_W-1:0] num_q [3];

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic          in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			amp_q       <= AMP_RST;
			gain_q      <= GAIN_RST;
			red_q       <= RED_RST;
			green_q     <= GREEN_RST;
			blue_q      <= BLUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_AMP:       amp_q       <= cfg_data[14:0];
				REG_GAIN:      gain_q      <= cfg_data[15:0];
				REG_RED:       red_q       <= cfg_data[15:0];
				REG_GREEN:     green_q     <= cfg_data[15:0];
				REG_BLUE:      blue_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The numerators only change with configuration, so they are registered
	// here from it and held steady ahead of any pixel reaching the dividers.
	always_comb begin
		wgt[0] = red_q;
		wgt[1] = green_q;
		wgt[2] = blue_q;
		for (int c = 0; c < 3; c++) begin
			wzero[c] = (wgt[c] == 16'd0);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			num_q[c] <= 32'(gain_q) * 32'(wgt[c]);
		end
	end

	// Stage enables: a stage loads when it is empty or its successor loads.
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign in_fire   = in_valid && in_ready;
	assign out_valid = vld_q[OUT_ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// The phase steps forward after the last pixel of each row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_phase_q <= '0;
		end else if (in_fire && (pixel_x == 11'(WIDTH - 1))) begin
			time_phase_q <= time_phase_q + {8'd0, time_step_q};
		end
	end

	// Stage 1: reciprocal multiplications for the normalized coordinates.
	logic [PROD_W-1:0] xprod_c, yprod_c;
	logic [XQ_W-1:0]   xq_s1, yq_s1;
	logic [31:0]       phase_s1;

	assign xprod_c = PROD_W'(pixel_x) * PROD_W'(PX_MUL);
	assign yprod_c = PROD_W'(pixel_y) * PROD_W'(PY_MUL);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xq_s1    <= xprod_c[PX_K +: XQ_W];
			yq_s1    <= yprod_c[PY_K +: XQ_W];
			phase_s1 <= time_phase_q;
		end
	end

	// Stage 2: saturate to Q2.14 and form the per-harmonic angles.
	logic signed [15:0] px_c, py_c, py_s2;
	logic [31:0]        pxe_c, base_c;
	logic [31:0]        ang_s2 [WAVES];

	always_comb begin
		px_c   = sat_q14($signed({2'b00, xq_s1}) - 25'sd16384);
		py_c   = sat_q14(25'sd16384 - $signed({2'b00, yq_s1}));
		pxe_c  = {{16{px_c[15]}}, px_c};
		base_c = pxe_c * TURN_PER_Q14 + phase_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			py_s2 <= py_c;
		end
	end

	disp_t disp_w [WAVES];

	for (genvar g = 0; g < WAVES; g++) begin : g_lane
		localparam logic [31:0] LANE_OFF = 32'(longint'(g) * longint'(TURN_PER_FIFTH));

		always_ff @(posedge clk) begin
			if (en[1]) begin
				ang_s2[g] <= base_c + LANE_OFF;
			end
		end

		swlps_sine u_sine (
			.clk  (clk),
			.en   (en[SIN_BASE +: SIN_STAGES]),
			.ang  (ang_s2[g]),
			.amp  (amp_q),
			.disp (disp_w[g])
		);
	end

	// The undisplaced y travels beside the sine lanes.
	logic signed [15:0] py_dly_s [SIN_STAGES];

	always_ff @(posedge clk) begin
		if (en[SIN_BASE]) begin
			py_dly_s[0] <= py_s2;
		end
		for (int k = 1; k < SIN_STAGES; k++) begin
			if (en[SIN_BASE+k]) begin
				py_dly_s[k] <= py_dly_s[k-1];
			end
		end
	end

	// Stage 8: running displaced y after each harmonic and its magnitude.
	logic [MAG_W-1:0] mag_c  [WAVES];
	logic [MAG_W-1:0] mag_s8 [WAVES];

	always_comb begin
		logic signed [SPY_W-1:0] acc;
		acc = {{(SPY_W-16){py_dly_s[SIN_STAGES-1][15]}}, py_dly_s[SIN_STAGES-1]};
		for (int w = 0; w < WAVES; w++) begin
			if (disp_w[w].neg) begin
				acc = acc - SPY_W'(disp_w[w].mag);
			end else begin
				acc = acc + SPY_W'(disp_w[w].mag);
			end
			mag_c[w] = acc[SPY_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
		end
	end

	always_ff @(posedge clk) begin
		if (en[SPY_ST]) begin
			for (int w = 0; w < WAVES; w++) begin
				mag_s8[w] <= mag_c[w];
			end
		end
	end

	// One divider per harmonic and color channel.
	logic [TERM_W-1:0] term_w [WAVES][3];

	for (genvar w = 0; w < WAVES; w++) begin : g_wave
		for (genvar c = 0; c < 3; c++) begin : g_chan
			swlps_div u_div (
				.clk   (clk),
				.en    (en[DIV_BASE +: DIV_STAGES]),
				.num   (num_q[c]),
				.wzero (wzero[c]),
				.mag   (mag_s8[w]),
				.term  (term_w[w][c])
			);
		end
	end

	// Stage 27: channel sums.
	logic [SUM_W-1:0] sum_c   [3];
	logic [SUM_W-1:0] sum_s27 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = '0;
			for (int w = 0; w < WAVES; w++) begin
				sum_c[c] = sum_c[c] + SUM_W'(term_w[w][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[SUM_ST]) begin
			for (int c = 0; c < 3; c++) begin
				sum_s27[c] <= sum_c[c];
			end
		end
	end

	// Stage 28: clamp to 1.0, scale by 255 as a shift and subtract, pack.
	logic [16:0] clamp_c [3];
	logic [24:0] scl_c   [3];
	logic [7:0]  byte_c  [3];
	logic [31:0] argb_s28;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			clamp_c[c] = (sum_s27[c] > SUM_W'(TERM_FULL_VAL)) ? TERM_FULL_VAL
				: sum_s27[c][16:0];
			scl_c[c]   = {clamp_c[c], 8'd0} - {8'd0, clamp_c[c]};
			byte_c[c]  = scl_c[c][23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[OUT_ST]) begin
			argb_s28 <= {ALPHA, byte_c[0], byte_c[1], byte_c[2]};
		end
	end

	assign argb = argb_s28;

`ifndef SYNTH
	// A result never goes out without its opaque alpha byte.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (argb[31:24] == ALPHA))
		else $error("result presented without full alpha");

	// Any empty stage anywhere in the pipeline must open the input.
	a_hole_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> in_ready)
		else $error("input stalled although the pipeline has a free stage");

	// A new result only appears when the sum stage held a valid item.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(vld_q[SUM_ST]))
		else $error("result appeared without a valid item behind it");
`endif

endmodule
